[rtl/assert_macros.svh]
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/isim_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isim_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = IDX_W + 1;
   localparam int VAL_W    = 16;
   localparam int ENTRY_W  = 2 * VAL_W;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   typedef enum logic [2:0] {
      RSP_ACCEPTED = 3'd0,
      RSP_FULL     = 3'd1,
      RSP_BAD      = 3'd2,
      RSP_ENTRY    = 3'd3,
      RSP_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [VAL_W-1:0] lo_bound;
      logic [VAL_W-1:0] hi_bound;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] out_lo;
      logic [VAL_W-1:0] out_hi;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_EV,
      S_FULL_CHK,
      S_COPY_RD,
      S_COPY_EV,
      S_COPY_ENT,
      S_TAIL,
      S_DONE,
      S_ECHO_BAD,
      S_ECHO_FULL,
      S_EMPTY,
      S_DRN_RD,
      S_DRN_EV
   } state_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_MERGED,
      SRC_ENTRY,
      SRC_EMPTY
   } emit_src_type;

   typedef struct packed {
      logic         load_req;
      logic         scan_acc;
      logic         idx_inc;
      logic         copy_start;
      logic         wr_merged;
      logic         wr_entry;
      logic         commit;
      logic         clear;
      logic         emit;
      emit_src_type src;
      status_type   st;
   } cmd_type;

   typedef struct packed {
      logic is_drain;
      logic bad;
      logic empty;
      logic full;
      logic idx_done;
      logic idx_last;
      logic hit_any;
      logic rd_hit;
      logic rd_place;
      logic placed;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/interval_set_insert_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sorted set of up to 16 disjoint closed intervals with merge on insert. One item is
// handled at a time. The table sits in one memory with a single registered read port, and
// a valid insert reads every entry twice, once to find the merged bounds and once to copy
// the table into the spare bank around the merged entry. A rejected insert and a drain of
// an empty table answer without reading the table; an insert dropped from a full table
// answers after the first pass. A drain returns each stored entry as a result of its own.
// The next item is taken once the result sits in the output register. No clearing pass
// follows reset.
module interval_set_insert_merge (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire isim_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output isim_pkg::rsp_type        rsp_data
);

   isim_pkg::cmd_type cmd;
   isim_pkg::sts_type sts;

   isim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   isim_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/isim_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module isim_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/isim_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module isim_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire isim_pkg::sts_type   sts,
   output isim_pkg::cmd_type        cmd
);

   isim_pkg::state_type state_ff;
   isim_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isim_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.src   = isim_pkg::SRC_INPUT;
      cmd.st    = isim_pkg::RSP_ACCEPTED;
      req_ready = 1'b0;
      case (state_ff)
         isim_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = isim_pkg::S_DISPATCH;
            end
         end
         isim_pkg::S_DISPATCH: begin
            if (sts.is_drain) begin
               state_in = sts.empty ? isim_pkg::S_EMPTY : isim_pkg::S_DRN_RD;
            end else if (sts.bad) begin
               state_in = isim_pkg::S_ECHO_BAD;
            end else begin
               state_in = isim_pkg::S_SCAN_RD;
            end
         end
         // First pass: fold every overlapping entry into the merged bounds.
         isim_pkg::S_SCAN_RD: begin
            state_in = sts.idx_done ? isim_pkg::S_FULL_CHK : isim_pkg::S_SCAN_EV;
         end
         isim_pkg::S_SCAN_EV: begin
            cmd.scan_acc = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = isim_pkg::S_SCAN_RD;
         end
         isim_pkg::S_FULL_CHK: begin
            if (!sts.hit_any && sts.full) begin
               state_in = isim_pkg::S_ECHO_FULL;
            end else begin
               cmd.copy_start = 1'b1;
               state_in       = isim_pkg::S_COPY_RD;
            end
         end
         // Second pass: rebuild the table into the other bank.
         isim_pkg::S_COPY_RD: begin
            state_in = sts.idx_done ? isim_pkg::S_TAIL : isim_pkg::S_COPY_EV;
         end
         isim_pkg::S_COPY_EV: begin
            if (sts.rd_hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = isim_pkg::S_COPY_RD;
            end else if (sts.rd_place) begin
               cmd.wr_merged = 1'b1;
               state_in      = isim_pkg::S_COPY_ENT;
            end else begin
               cmd.wr_entry = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = isim_pkg::S_COPY_RD;
            end
         end
         isim_pkg::S_COPY_ENT: begin
            cmd.wr_entry = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = isim_pkg::S_COPY_RD;
         end
         isim_pkg::S_TAIL: begin
            cmd.wr_merged = !sts.placed;
            cmd.commit    = 1'b1;
            state_in      = isim_pkg::S_DONE;
         end
         isim_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               cmd.src  = isim_pkg::SRC_MERGED;
               cmd.st   = isim_pkg::RSP_ACCEPTED;
               state_in = isim_pkg::S_IDLE;
            end
         end
         isim_pkg::S_ECHO_BAD: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               cmd.src  = isim_pkg::SRC_INPUT;
               cmd.st   = isim_pkg::RSP_BAD;
               state_in = isim_pkg::S_IDLE;
            end
         end
         isim_pkg::S_ECHO_FULL: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               cmd.src  = isim_pkg::SRC_INPUT;
               cmd.st   = isim_pkg::RSP_FULL;
               state_in = isim_pkg::S_IDLE;
            end
         end
         isim_pkg::S_EMPTY: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               cmd.src  = isim_pkg::SRC_EMPTY;
               cmd.st   = isim_pkg::RSP_EMPTY;
               state_in = isim_pkg::S_IDLE;
            end
         end
         isim_pkg::S_DRN_RD: begin
            state_in = isim_pkg::S_DRN_EV;
         end
         isim_pkg::S_DRN_EV: begin
            if (sts.rsp_free) begin
               cmd.emit    = 1'b1;
               cmd.src     = isim_pkg::SRC_ENTRY;
               cmd.st      = isim_pkg::RSP_ENTRY;
               cmd.idx_inc = 1'b1;
               if (sts.idx_last) begin
                  cmd.clear = 1'b1;
                  state_in  = isim_pkg::S_IDLE;
               end else begin
                  state_in = isim_pkg::S_DRN_RD;
               end
            end
         end
         default: begin
            state_in = isim_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/isim_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module isim_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire isim_pkg::req_type   req_data,
   input  wire isim_pkg::cmd_type   cmd,
   output isim_pkg::sts_type        sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output isim_pkg::rsp_type        rsp_data
);

   localparam int IW = isim_pkg::IDX_W;
   localparam int CW = isim_pkg::CNT_W;
   localparam int VW = isim_pkg::VAL_W;

   logic          kind_ff;
   logic [VW-1:0] lo_ff, lo_in;
   logic [VW-1:0] hi_ff, hi_in;
   logic [VW-1:0] mlo_ff, mlo_in;
   logic [VW-1:0] mhi_ff, mhi_in;
   logic          hit_ff, hit_in;
   logic          placed_ff, placed_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] m_ff, m_in;
   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff, bank_in;
   logic          rsp_valid_ff, rsp_valid_in;
   isim_pkg::rsp_type rsp_ff, rsp_in;

   logic                             wr_en;
   logic [isim_pkg::ADDR_W-1:0]      wr_addr;
   logic [isim_pkg::ENTRY_W-1:0]     wr_data;
   logic [isim_pkg::ADDR_W-1:0]      rd_addr;
   logic [isim_pkg::ENTRY_W-1:0]     rd_data;
   logic [VW-1:0]                    rd_lo;
   logic [VW-1:0]                    rd_hi;
   logic                             rd_hit;
   logic                             rsp_free;

   // Two banks: the live table is read from one while the rebuilt one is written to the other.
   assign rd_addr = {bank_ff, idx_ff[IW-1:0]};
   assign wr_addr = {~bank_ff, m_ff[IW-1:0]};
   assign wr_en   = cmd.wr_merged | cmd.wr_entry;
   assign wr_data = cmd.wr_merged ? {mlo_ff, mhi_ff} : rd_data;

   isim_ram #(
      .WIDTH (isim_pkg::ENTRY_W),
      .DEPTH (2 * isim_pkg::CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_lo    = rd_data[isim_pkg::ENTRY_W-1:VW];
   assign rd_hi    = rd_data[VW-1:0];
   assign rd_hit   = (rd_hi >= lo_ff) && (rd_lo <= hi_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts          = '0;
      sts.is_drain = (kind_ff == isim_pkg::KIND_DRAIN);
      sts.bad      = lo_ff > hi_ff;
      sts.empty    = count_ff == '0;
      sts.full     = count_ff == isim_pkg::CAP_CNT;
      sts.idx_done = idx_ff == count_ff;
      sts.idx_last = (idx_ff + CW'(1)) == count_ff;
      sts.hit_any  = hit_ff;
      sts.rd_hit   = rd_hit;
      sts.rd_place = !placed_ff && (rd_lo > mhi_ff);
      sts.placed   = placed_ff;
      sts.rsp_free = rsp_free;
   end

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      hit_in       = hit_ff;
      placed_in    = placed_ff;
      idx_in       = idx_ff;
      m_in         = m_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         lo_in     = req_data.lo_bound;
         hi_in     = req_data.hi_bound;
         mlo_in    = req_data.lo_bound;
         mhi_in    = req_data.hi_bound;
         hit_in    = 1'b0;
         placed_in = 1'b0;
         idx_in    = '0;
         m_in      = '0;
      end
      if (cmd.scan_acc && rd_hit) begin
         hit_in = 1'b1;
         if (rd_lo < mlo_ff) begin
            mlo_in = rd_lo;
         end
         if (rd_hi > mhi_ff) begin
            mhi_in = rd_hi;
         end
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.copy_start) begin
         idx_in = '0;
      end
      if (wr_en) begin
         m_in = m_ff + CW'(1);
      end
      if (cmd.wr_merged) begin
         placed_in = 1'b1;
      end
      // Swap banks; the merged entry written alongside counts toward the new size.
      if (cmd.commit) begin
         bank_in  = ~bank_ff;
         count_in = cmd.wr_merged ? m_ff + CW'(1) : m_ff;
      end
      if (cmd.clear) begin
         count_in = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = cmd.st;
         rsp_in.last   = 1'b1;
         case (cmd.src)
            isim_pkg::SRC_INPUT: begin
               rsp_in.out_lo = lo_ff;
               rsp_in.out_hi = hi_ff;
            end
            isim_pkg::SRC_MERGED: begin
               rsp_in.out_lo = mlo_ff;
               rsp_in.out_hi = mhi_ff;
            end
            isim_pkg::SRC_ENTRY: begin
               rsp_in.out_lo = rd_lo;
               rsp_in.out_hi = rd_hi;
               rsp_in.last   = sts.idx_last;
            end
            default: begin
               rsp_in.out_lo = '0;
               rsp_in.out_hi = '0;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_data.kind;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mlo_ff    <= mlo_in;
      mhi_ff    <= mhi_in;
      hit_ff    <= hit_in;
      placed_ff <= placed_in;
      idx_ff    <= idx_in;
      m_ff      <= m_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_cap, clock, reset, count_ff <= isim_pkg::CAP_CNT, "count above capacity")
   `ASSERT_IMPLY(a_wr_range, clock, reset, wr_en, m_ff < isim_pkg::CAP_CNT, "write past capacity")
   `ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready, "result overrun")

endmodule

`default_nettype wire

[verif/interval_set_insert_merge_test.sv]
`timescale 1ns / 1ps

module interval_set_insert_merge_test;

   localparam int VW           = isim_pkg::VAL_W;
   localparam int CAP          = isim_pkg::CAPACITY;
   localparam int QUIET_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 75;
   localparam int FILL_STRIDE  = 10;

   typedef struct {
      logic              kind;
      logic [VW-1:0]     lo;
      logic [VW-1:0]     hi;
      int                reps;
      bit                typed;
      isim_pkg::rsp_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   isim_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   isim_pkg::rsp_type rsp_data;

   int          send_idle_pct = 13;
   int          rsp_stall_pct = 45;
   logic        rsp_hold = 1'b0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   // shadow copy of the interval table
   logic [VW-1:0] tbl_lo[CAP];
   logic [VW-1:0] tbl_hi[CAP];
   int            tbl_count = 0;

   isim_pkg::rsp_type fresh_rsps[$];
   isim_pkg::rsp_type awaited_rsps[$];
   stim_row_type      directed_rows[$];

   interval_set_insert_merge dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic isim_pkg::rsp_type mk_rsp(isim_pkg::status_type st, logic [VW-1:0] lo,
                                                logic [VW-1:0] hi, logic last);
      isim_pkg::rsp_type r;
      r.status = st;
      r.out_lo = lo;
      r.out_hi = hi;
      r.last   = last;
      return r;
   endfunction

   function automatic void add_fresh(isim_pkg::rsp_type r);
      fresh_rsps = {fresh_rsps, r};
   endfunction

   // Apply one request to the shadow table and leave its results in fresh_rsps.
   function automatic void merge_into_table(isim_pkg::req_type r);
      logic [VW-1:0] mlo;
      logic [VW-1:0] mhi;
      logic [VW-1:0] nlo[CAP];
      logic [VW-1:0] nhi[CAP];
      int            i;
      int            m;
      int            hits;
      bit            placed;
      fresh_rsps.delete();
      if (r.kind == isim_pkg::KIND_DRAIN) begin
         if (tbl_count == 0) begin
            add_fresh(mk_rsp(isim_pkg::RSP_EMPTY, '0, '0, 1'b1));
         end else begin
            for (i = 0; i < tbl_count; i++)
               add_fresh(mk_rsp(isim_pkg::RSP_ENTRY, tbl_lo[i], tbl_hi[i],
                                i == tbl_count - 1));
         end
         tbl_count = 0;
         return;
      end
      if (r.lo_bound > r.hi_bound) begin
         add_fresh(mk_rsp(isim_pkg::RSP_BAD, r.lo_bound, r.hi_bound, 1'b1));
         return;
      end
      mlo  = r.lo_bound;
      mhi  = r.hi_bound;
      hits = 0;
      for (i = 0; i < tbl_count; i++) begin
         if (tbl_hi[i] >= r.lo_bound && tbl_lo[i] <= r.hi_bound) begin
            hits++;
            if (tbl_lo[i] < mlo) mlo = tbl_lo[i];
            if (tbl_hi[i] > mhi) mhi = tbl_hi[i];
         end
      end
      if (hits == 0 && tbl_count >= CAP) begin
         add_fresh(mk_rsp(isim_pkg::RSP_FULL, r.lo_bound, r.hi_bound, 1'b1));
         return;
      end
      // rebuild: keep untouched entries in order, slot the merged one in place
      m      = 0;
      placed = 1'b0;
      for (i = 0; i < tbl_count; i++) begin
         if (tbl_hi[i] >= r.lo_bound && tbl_lo[i] <= r.hi_bound) continue;
         if (!placed && tbl_lo[i] > mhi) begin
            nlo[m] = mlo;
            nhi[m] = mhi;
            m++;
            placed = 1'b1;
         end
         if (m < CAP) begin
            nlo[m] = tbl_lo[i];
            nhi[m] = tbl_hi[i];
            m++;
         end
      end
      if (!placed && m < CAP) begin
         nlo[m] = mlo;
         nhi[m] = mhi;
         m++;
      end
      for (i = 0; i < m; i++) begin
         tbl_lo[i] = nlo[i];
         tbl_hi[i] = nhi[i];
      end
      tbl_count = m;
      add_fresh(mk_rsp(isim_pkg::RSP_ACCEPTED, mlo, mhi, 1'b1));
   endfunction

   function automatic isim_pkg::req_type random_request();
      isim_pkg::req_type r;
      int unsigned       pick;
      int unsigned       span;
      pick       = $urandom_range(99);
      r.kind     = isim_pkg::KIND_INSERT;
      r.lo_bound = VW'($urandom);
      r.hi_bound = VW'($urandom);
      if (pick < 6) begin
         r.kind = isim_pkg::KIND_DRAIN;
      end else if (pick < 11) begin
         r.lo_bound = VW'($urandom_range(65535, 1));
         r.hi_bound = VW'($urandom_range(r.lo_bound - 1, 0));
      end else if (pick < 18) begin
         case ($urandom_range(3))
            0: begin
               r.lo_bound = '0;
            end
            1: begin
               r.lo_bound = VW'($urandom_range(65535));
               r.hi_bound = '1;
            end
            2: begin
               r.lo_bound = '1;
               r.hi_bound = '1;
            end
            default: begin
               r.lo_bound = '0;
               r.hi_bound = '1;
            end
         endcase
      end else if (pick < 60) begin
         // crowd a narrow window so overlaps and shared ends are common
         r.lo_bound = VW'($urandom_range(240));
         r.hi_bound = r.lo_bound + VW'($urandom_range(15));
      end else begin
         span       = $urandom_range(2000);
         r.lo_bound = VW'($urandom_range(65535 - span));
         r.hi_bound = r.lo_bound + VW'(span);
      end
      return r;
   endfunction

   function automatic void add_row(logic kind, logic [VW-1:0] lo, logic [VW-1:0] hi,
                                   int reps, bit typed, isim_pkg::rsp_type want);
      stim_row_type row;
      row.kind  = kind;
      row.lo    = lo;
      row.hi    = hi;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      directed_rows = {directed_rows, row};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Offer one beat, hold it until taken, then record what it should produce.
   task automatic offer_request(input isim_pkg::req_type r, input bit typed,
                                input isim_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      merge_into_table(r);
      if (typed) begin
         awaited_rsps = {awaited_rsps, want};
      end else begin
         foreach (fresh_rsps[j]) awaited_rsps = {awaited_rsps, fresh_rsps[j]};
      end
   endtask

   always @(posedge clock) begin
      isim_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsps.size() == 0) begin
            report_mismatch($sformatf("result beat with none pending: %h", rsp_data));
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.out_lo !== want.out_lo)
               report_mismatch($sformatf("out_lo got %0d want %0d",
                                         rsp_data.out_lo, want.out_lo));
            if (rsp_data.out_hi !== want.out_hi)
               report_mismatch($sformatf("out_hi got %0d want %0d",
                                         rsp_data.out_hi, want.out_hi));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last got %0b want %0b",
                                         rsp_data.last, want.last));
         end
      end
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      isim_pkg::req_type r;
      stim_row_type      row;
      int                ph;
      int                k;
      add_row(isim_pkg::KIND_DRAIN, 16'd0, 16'd0, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_EMPTY, 16'd0, 16'd0, 1'b1));
      add_row(isim_pkg::KIND_INSERT, 16'hFFFF, 16'd0, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_BAD, 16'hFFFF, 16'd0, 1'b1));
      add_row(isim_pkg::KIND_INSERT, 16'd0, 16'd0, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_ACCEPTED, 16'd0, 16'd0, 1'b1));
      add_row(isim_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_ACCEPTED, 16'hFFFF, 16'hFFFF, 1'b1));
      // adjacent only, then a bridge that shares an end with both
      add_row(isim_pkg::KIND_INSERT, 16'd1, 16'd2, 1, 1'b0, '0);
      add_row(isim_pkg::KIND_INSERT, 16'd3, 16'd4, 1, 1'b0, '0);
      add_row(isim_pkg::KIND_INSERT, 16'd2, 16'd3, 1, 1'b0, '0);
      // fill the table to capacity, then overflow it and merge while full
      add_row(isim_pkg::KIND_INSERT, 16'd10, 16'd15, 13, 1'b0, '0);
      add_row(isim_pkg::KIND_INSERT, 16'd7, 16'd7, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_FULL, 16'd7, 16'd7, 1'b1));
      add_row(isim_pkg::KIND_INSERT, 16'd15, 16'd20, 1, 1'b0, '0);
      add_row(isim_pkg::KIND_DRAIN, 16'hA5A5, 16'h5A5A, 1, 1'b0, '0);
      add_row(isim_pkg::KIND_DRAIN, 16'd0, 16'd0, 1, 1'b1,
              mk_rsp(isim_pkg::RSP_EMPTY, 16'd0, 16'd0, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 45 : 0;
         rsp_stall_pct = (ph == 0) ? 45 : (ph == 1) ? 13 : 0;
         if (ph == 0) begin
            foreach (directed_rows[n]) begin
               row = directed_rows[n];
               for (k = 0; k < row.reps; k++) begin
                  r.kind     = row.kind;
                  r.lo_bound = row.lo + VW'(k * FILL_STRIDE);
                  r.hi_bound = row.hi + VW'(k * FILL_STRIDE);
                  offer_request(r, row.typed, row.want);
               end
            end
         end
         if (ph == 2) begin
            // back up the result side while requests keep coming
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         repeat (PHASE_ITEMS) offer_request(random_request(), 1'b0, '0);
         req_valid <= 1'b0;
         do @(posedge clock); while (awaited_rsps.size() != 0);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/isim_pkg.sv
rtl/isim_ram.sv
rtl/isim_ctrl.sv
rtl/isim_dp.sv
rtl/interval_set_insert_merge.sv
verif/interval_set_insert_merge_test.sv
